FILE: rtl/core/dbba_pkg.sv
// ----------------------------------------------------------------------------
// dbba_pkg
// Shared codes, widths and the lowest-clear-bit finder for the block
// bitmap allocator.
// ----------------------------------------------------------------------------
package dbba_pkg;

    // map memory word width
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;

    // field widths
    localparam int REQ_W    = 2;
    localparam int IDX_W    = 10;
    localparam int BYTES_W  = 16;
    localparam int STATUS_W = 3;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CHECK = 2'd2;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_ALLOC = 3'd2,
        ST_RANGE     = 3'd3,
        ST_PAST_END  = 3'd4
    } t_status;

    // lowest clear bit of a word: {found, position}
    function automatic logic [BIT_W:0] first_zero(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] inv;
        logic [WORD_W-1:0] iso;
        logic [BIT_W-1:0]  pos;
        inv = ~w;
        iso = inv & (~inv + WORD_W'(1));
        pos = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (iso[i]) begin
                pos = pos | BIT_W'(i);
            end
        end
        return {(inv != '0), pos};
    endfunction

endpackage

FILE: rtl/core/dbba_map_mem.sv
// ----------------------------------------------------------------------------
// dbba_map_mem
// Used-map storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dbba_map_mem #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    output logic [dbba_pkg::WORD_W-1:0] o_rd_data,
    input  logic                       i_wr_en,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic [dbba_pkg::WORD_W-1:0] i_wr_data
);

    logic [dbba_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [dbba_pkg::WORD_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/dbba_seq.sv
// ----------------------------------------------------------------------------
// dbba_seq
// Request sequencer: clearing pass, word-by-word first-fit scan, and the
// used-bit read for free and check, written back on a free, in the map memory.
// ----------------------------------------------------------------------------
module dbba_seq #(
    parameter int BLOCK_COUNT = 1024,
    parameter int MAP_WORDS   = 32,
    parameter int ADDR_W      = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [dbba_pkg::REQ_W-1:0]      i_req_type,
    input  logic [dbba_pkg::IDX_W-1:0]      i_block_index,
    input  logic [dbba_pkg::BYTES_W-1:0]    i_byte_offset,
    input  logic [dbba_pkg::BYTES_W-1:0]    i_byte_count,
    input  logic [dbba_pkg::BYTES_W-1:0]    i_block_bytes,
    output logic                            o_done,
    output logic [dbba_pkg::STATUS_W-1:0]   o_status,
    output logic [dbba_pkg::IDX_W-1:0]      o_result_index,
    output logic                            o_rd_en,
    output logic [ADDR_W-1:0]               o_rd_addr,
    input  logic [dbba_pkg::WORD_W-1:0]     i_rd_data,
    output logic                            o_wr_en,
    output logic [ADDR_W-1:0]               o_wr_addr,
    output logic [dbba_pkg::WORD_W-1:0]     o_wr_data
);

    localparam int                 WORD_W    = dbba_pkg::WORD_W;
    localparam int                 BIT_W     = dbba_pkg::BIT_W;
    localparam int                 IDX_W     = dbba_pkg::IDX_W;
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(MAP_WORDS - 1);
    localparam int                 LAST_BITS = BLOCK_COUNT - (MAP_WORDS - 1) * WORD_W;
    // bits past the end of the map in the last word read as used
    localparam logic [WORD_W-1:0]  PAD_MASK  = {WORD_W{1'b1}} << LAST_BITS;
    localparam logic [16:0]        COUNT_EXT = 17'(BLOCK_COUNT);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_LOOK  = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic [ADDR_W-1:0]               r_clr_addr, n_clr_addr;
    logic [ADDR_W-1:0]               r_rd_addr, n_rd_addr;
    logic                            r_rd_more, n_rd_more;
    logic                            r_pend, n_pend;
    logic [ADDR_W-1:0]               r_pend_addr, n_pend_addr;
    logic [ADDR_W-1:0]               r_word, n_word;
    logic [BIT_W-1:0]                r_bit, n_bit;
    logic [IDX_W-1:0]                r_idx, n_idx;
    logic [dbba_pkg::REQ_W-1:0]      r_req, n_req;
    logic                            r_need_bit, n_need_bit;
    dbba_pkg::t_status               r_pre_status, n_pre_status;
    logic                            r_done, n_done;
    dbba_pkg::t_status               r_status, n_status;
    logic [IDX_W-1:0]                r_res, n_res;

    logic [WORD_W-1:0]               scan_word;
    logic [BIT_W:0]                  scan_find;
    logic                            scan_hit;
    logic [16:0]                     in_idx_ext;
    logic                            in_range;
    logic                            past_end;
    logic                            look_bit;

    // scan of the word read last cycle
    always_comb begin
        scan_word = i_rd_data | ((r_pend_addr == LAST_ADDR) ? PAD_MASK : '0);
        scan_find = dbba_pkg::first_zero(scan_word);
        scan_hit  = r_pend & scan_find[BIT_W];
    end

    // request decode at accept
    always_comb begin
        in_idx_ext = 17'(i_block_index);
        in_range   = in_idx_ext < COUNT_EXT;
        past_end   = ({1'b0, i_byte_offset} + {1'b0, i_byte_count})
                     > {1'b0, i_block_bytes};
        look_bit   = i_rd_data[r_bit];
    end

    // next state and memory control
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_rd_addr    = r_rd_addr;
        n_rd_more    = r_rd_more;
        n_pend       = 1'b0;
        n_pend_addr  = r_rd_addr;
        n_word       = r_word;
        n_bit        = r_bit;
        n_idx        = r_idx;
        n_req        = r_req;
        n_need_bit   = r_need_bit;
        n_pre_status = r_pre_status;
        n_done       = 1'b0;
        n_status     = r_status;
        n_res        = r_res;
        o_rd_en      = 1'b0;
        o_rd_addr    = r_rd_addr;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_clr_addr;
        o_wr_data    = '0;

        case (r_state)
            // clearing pass: word 0 keeps block 0 reserved
            S_CLEAR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_clr_addr;
                o_wr_data = (r_clr_addr == '0) ? WORD_W'(1) : '0;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + ADDR_W'(1);
                end
            end

            // take a new word
            S_IDLE: begin
                if (i_start) begin
                    n_req = i_req_type;
                    n_idx = i_block_index;
                    n_word = ADDR_W'(i_block_index[IDX_W-1:BIT_W]);
                    n_bit = i_block_index[BIT_W-1:0];
                    if (i_req_type == dbba_pkg::REQ_ALLOC) begin
                        n_state   = S_SCAN;
                        n_rd_addr = '0;
                        n_rd_more = 1'b1;
                    end else begin
                        n_state      = S_LOOK;
                        n_need_bit   = 1'b0;
                        n_pre_status = dbba_pkg::ST_OK;
                        if (i_req_type != dbba_pkg::REQ_FREE &&
                            i_req_type != dbba_pkg::REQ_CHECK) begin
                            n_pre_status = dbba_pkg::ST_OK;
                        end else if (!in_range) begin
                            n_pre_status = dbba_pkg::ST_RANGE;
                        end else if (i_req_type == dbba_pkg::REQ_CHECK && past_end) begin
                            n_pre_status = dbba_pkg::ST_PAST_END;
                        end else begin
                            n_need_bit = 1'b1;
                            o_rd_en    = 1'b1;
                            o_rd_addr  = ADDR_W'(i_block_index[IDX_W-1:BIT_W]);
                        end
                    end
                end
            end

            // first-fit scan, one word read per cycle
            S_SCAN: begin
                if (scan_hit) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_pend_addr;
                    o_wr_data = i_rd_data | (WORD_W'(1) << scan_find[BIT_W-1:0]);
                    n_done    = 1'b1;
                    n_status  = dbba_pkg::ST_OK;
                    n_res     = IDX_W'({r_pend_addr, scan_find[BIT_W-1:0]});
                    n_state   = S_IDLE;
                end else if (r_pend && r_pend_addr == LAST_ADDR) begin
                    n_done   = 1'b1;
                    n_status = dbba_pkg::ST_FULL;
                    n_res    = '0;
                    n_state  = S_IDLE;
                end else if (r_rd_more) begin
                    o_rd_en     = 1'b1;
                    o_rd_addr   = r_rd_addr;
                    n_pend      = 1'b1;
                    n_pend_addr = r_rd_addr;
                    n_rd_more   = (r_rd_addr != LAST_ADDR);
                    n_rd_addr   = r_rd_addr + ADDR_W'(1);
                end
            end

            // free or check against the used bit
            S_LOOK: begin
                n_done  = 1'b1;
                n_res   = r_idx;
                n_state = S_IDLE;
                if (!r_need_bit) begin
                    n_status = r_pre_status;
                end else if (!look_bit) begin
                    n_status = dbba_pkg::ST_NOT_ALLOC;
                end else begin
                    n_status = dbba_pkg::ST_OK;
                    if (r_req == dbba_pkg::REQ_FREE) begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_word;
                        o_wr_data = i_rd_data & ~(WORD_W'(1) << r_bit);
                    end
                end
            end

            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_rd_more  <= 1'b0;
            r_pend     <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_rd_more  <= n_rd_more;
            r_pend     <= n_pend;
            r_done     <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_addr    <= n_rd_addr;
        r_pend_addr  <= n_pend_addr;
        r_word       <= n_word;
        r_bit        <= n_bit;
        r_idx        <= n_idx;
        r_req        <= n_req;
        r_need_bit   <= n_need_bit;
        r_pre_status <= n_pre_status;
        r_status     <= n_status;
        r_res        <= n_res;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_result_index = r_res;

    // checks
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_rd_en && o_wr_en))
        else $error("map read and write in the same cycle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe while still busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted word did not raise busy");

    a_done_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_state) == S_SCAN || $past(r_state) == S_LOOK))
        else $error("result strobe without a word in progress");

    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_state != S_SCAN) |-> $past(r_state) == S_SCAN)
        else $error("stray pending read outside the scan");

endmodule

FILE: rtl/core/data_block_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// data_block_bitmap_allocator
// First-fit block allocator over a one-bit-per-block used map held in a
// 32-bit-wide synchronous memory.
//
//   channel   ports                                       handshake
//   request   i_req_type i_block_index i_byte_offset      start & !busy
//             i_byte_count
//   result    o_status o_result_index                     o_done, one cycle
//   config    i_cfg_data (block_bytes)                    i_cfg_we
//
// Allocate reads the map one word per cycle through the single map read
// port, from word 0 until the first clear bit is found or the last word
// is read; free and check read at most the one word holding the block's bit.
// After reset a clearing pass writes every map word with busy high;
// configuration writes are taken at any time.
// The result strobe cannot be held off; the next word can be taken in
// the same cycle as the strobe.
// ----------------------------------------------------------------------------
module data_block_bitmap_allocator #(
    parameter int BLOCK_COUNT = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [dbba_pkg::REQ_W-1:0]      i_req_type,
    input  logic [dbba_pkg::IDX_W-1:0]      i_block_index,
    input  logic [dbba_pkg::BYTES_W-1:0]    i_byte_offset,
    input  logic [dbba_pkg::BYTES_W-1:0]    i_byte_count,
    input  logic                            i_cfg_we,
    input  logic [dbba_pkg::BYTES_W-1:0]    i_cfg_data,
    output logic                            o_done,
    output logic [dbba_pkg::STATUS_W-1:0]   o_status,
    output logic [dbba_pkg::IDX_W-1:0]      o_result_index
);

    localparam int MAP_WORDS = (BLOCK_COUNT + dbba_pkg::WORD_W - 1) / dbba_pkg::WORD_W;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic [dbba_pkg::BYTES_W-1:0] r_block_bytes;
    logic                         rd_en;
    logic [ADDR_W-1:0]            rd_addr;
    logic [dbba_pkg::WORD_W-1:0]  rd_data;
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic [dbba_pkg::WORD_W-1:0]  wr_data;

    // block size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= dbba_pkg::BYTES_W'(1024);
        end else if (i_cfg_we) begin
            r_block_bytes <= i_cfg_data;
        end
    end

    // used map
    dbba_map_mem #(
        .DEPTH  (MAP_WORDS),
        .ADDR_W (ADDR_W)
    ) u_map (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // request sequencer
    dbba_seq #(
        .BLOCK_COUNT (BLOCK_COUNT),
        .MAP_WORDS   (MAP_WORDS),
        .ADDR_W      (ADDR_W)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .i_req_type     (i_req_type),
        .i_block_index  (i_block_index),
        .i_byte_offset  (i_byte_offset),
        .i_byte_count   (i_byte_count),
        .i_block_bytes  (r_block_bytes),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_result_index (o_result_index),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data)
    );

endmodule
